// ----- sv/ebalu_pkg.sv -----
// ----------------------------------------------------------------------------
// ebalu_pkg
// Shared types and constants of the eight-bit ALU with flags.
// ----------------------------------------------------------------------------
`default_nettype none

package ebalu_pkg;

  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);

  localparam logic [REG_AW-1:0] ACC_INDEX = REG_AW'(7);

  localparam int unsigned CMD_W  = 5;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned BIT_W  = $clog2(DATA_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_INC_REG = 5'd0,
    CMD_DEC_REG = 5'd1,
    CMD_INC_VAL = 5'd2,
    CMD_DEC_VAL = 5'd3,
    CMD_ADD_REG = 5'd4,
    CMD_LOAD    = 5'd5,
    CMD_COPY    = 5'd6,
    CMD_RL      = 5'd7,
    CMD_RR      = 5'd8,
    CMD_CPL     = 5'd9,
    CMD_ADD     = 5'd10,
    CMD_ADC     = 5'd11,
    CMD_SUB     = 5'd12,
    CMD_SBC     = 5'd13,
    CMD_CP      = 5'd14,
    CMD_AND     = 5'd15,
    CMD_XOR     = 5'd16,
    CMD_OR      = 5'd17,
    CMD_BIT     = 5'd18,
    CMD_RES     = 5'd19,
    CMD_SET     = 5'd20,
    CMD_SCF     = 5'd21,
    CMD_CCF     = 5'd22,
    CMD_CLEAR   = 5'd23
  } cmd_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // One operation as held in the execute stage
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REG_AW-1:0] rid;
    logic [DATA_W-1:0] opd;
    logic [BIT_W-1:0]  bidx;
    logic              circ;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

endpackage

`default_nettype wire

// ----- sv/ebalu_if.sv -----
// ----------------------------------------------------------------------------
// ebalu_if
// Valid/ready channels for operations in and flag/result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebalu_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] command;
  logic [2:0] reg_id;
  logic [2:0] src_reg_id;
  logic [7:0] operand;
  logic [2:0] bit_index;
  logic       circular;

  modport source (
    output valid, command, reg_id, src_reg_id, operand, bit_index, circular,
    input  ready
  );
  modport sink (
    input  valid, command, reg_id, src_reg_id, operand, bit_index, circular,
    output ready
  );
endinterface

interface ebalu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       zero_bit;
  logic       subtract_flag;
  logic       half_carry_bit;
  logic       carry_bit;

  modport source (
    output valid, result, zero_bit, subtract_flag, half_carry_bit, carry_bit,
    input  ready
  );
  modport sink (
    input  valid, result, zero_bit, subtract_flag, half_carry_bit, carry_bit,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/eight_bit_alu_with_flags_core.sv -----
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core
// Eight-bit CPU ALU with register file, Z/N/H/C flags and last result.
// ----------------------------------------------------------------------------
// Each transfer on item_i carries one operation. The block reads its source
// register (or the copy source) and the accumulator while taking the
// transfer into the execute register, runs the operation in one pass, and
// updates the register file, flags and last-result byte at the edge that
// hands the new result and flags to the output register. Throughput is one
// operation per cycle unless res_o stalls. Operations may follow each other
// back to back: a register written by one operation is bypassed to the read
// of the next. Unused command codes change nothing and return the current
// result and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_alu_with_flags_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  ebalu_in_if.sink    item_i,
  ebalu_out_if.source res_o
);

  logic                          stg_valid_q;
  logic                          stg_valid_d;
  ebalu_pkg::item_t              stg_q;
  logic                          out_valid_q;
  logic                          out_valid_d;
  ebalu_pkg::flags_t             flags_q;
  ebalu_pkg::flags_t             flags_d;
  logic [ebalu_pkg::DATA_W-1:0]  last_q;
  logic [ebalu_pkg::DATA_W-1:0]  last_d;
  logic                          adv;
  logic                          in_xfer;
  logic [ebalu_pkg::REG_AW-1:0]  rd_addr;
  logic [ebalu_pkg::DATA_W-1:0]  reg_val;
  logic [ebalu_pkg::DATA_W-1:0]  acc_val;
  ebalu_pkg::wr_req_t            exec_wr;
  ebalu_pkg::wr_req_t            rf_wr;

  assign adv          = stg_valid_q && (!out_valid_q || res_o.ready);
  assign item_i.ready = !stg_valid_q || adv;
  assign in_xfer      = item_i.valid && item_i.ready;

  assign rd_addr = (ebalu_pkg::cmd_e'(item_i.command) == ebalu_pkg::CMD_COPY)
                   ? item_i.src_reg_id : item_i.reg_id;

  ebalu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (rd_addr),
    .wr_i      (rf_wr),
    .rd_data_o (reg_val),
    .acc_o     (acc_val)
  );

  ebalu_exec u_exec (
    .item_i    (stg_q),
    .reg_val_i (reg_val),
    .acc_i     (acc_val),
    .flags_i   (flags_q),
    .last_i    (last_q),
    .flags_o   (flags_d),
    .last_o    (last_d),
    .wr_o      (exec_wr)
  );

  always_comb begin
    rf_wr    = exec_wr;
    rf_wr.en = exec_wr.en && adv;
  end

  always_comb begin
    if (in_xfer) begin
      stg_valid_d = 1'b1;
    end else if (adv) begin
      stg_valid_d = 1'b0;
    end else begin
      stg_valid_d = stg_valid_q;
    end
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      last_q      <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        flags_q <= flags_d;
        last_q  <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stg_q <= '{cmd:  item_i.command,
                 rid:  item_i.reg_id,
                 opd:  item_i.operand,
                 bidx: item_i.bit_index,
                 circ: item_i.circular};
    end
  end

  // last result and flags only move on an advance, so they form the output
  // register together with out_valid_q
  assign res_o.valid          = out_valid_q;
  assign res_o.result         = last_q;
  assign res_o.zero_bit       = flags_q.z;
  assign res_o.subtract_flag  = flags_q.n;
  assign res_o.half_carry_bit = flags_q.h;
  assign res_o.carry_bit      = flags_q.c;

`ifndef SYNTH
  a_scf_sets_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && ebalu_pkg::cmd_e'(stg_q.cmd) == ebalu_pkg::CMD_SCF |=> flags_q.c)
    else $error("scf did not set carry");

  a_ccf_flips_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && ebalu_pkg::cmd_e'(stg_q.cmd) == ebalu_pkg::CMD_CCF
    |=> flags_q.c != $past(flags_q.c))
    else $error("ccf did not complement carry");

  a_load_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (ebalu_pkg::cmd_e'(stg_q.cmd) == ebalu_pkg::CMD_LOAD ||
            ebalu_pkg::cmd_e'(stg_q.cmd) == ebalu_pkg::CMD_COPY)
    |=> last_q == $past(last_q) && flags_q == $past(flags_q))
    else $error("load or copy changed result or flags");

  a_state_only_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(last_q) && $stable(flags_q))
    else $error("state changed without an executed operation");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stg_valid_q |-> item_i.ready)
    else $error("empty execute stage refused input");
`endif

endmodule

`default_nettype wire

// ----- sv/ebalu_regfile.sv -----
// ----------------------------------------------------------------------------
// ebalu_regfile
// Eight-entry byte register file, one write port, one addressed read port
// and an accumulator read port, both registered with write-first bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module ebalu_regfile (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 rd_en_i,
  input  wire  [ebalu_pkg::REG_AW-1:0]        rd_addr_i,
  input  wire  ebalu_pkg::wr_req_t            wr_i,
  output logic [ebalu_pkg::DATA_W-1:0]        rd_data_o,
  output logic [ebalu_pkg::DATA_W-1:0]        acc_o
);

  logic [ebalu_pkg::DATA_W-1:0]    mem [ebalu_pkg::REG_COUNT];
  logic [ebalu_pkg::REG_COUNT-1:0] vld_q;
  logic [ebalu_pkg::DATA_W-1:0]    rd_data_q;
  logic [ebalu_pkg::DATA_W-1:0]    acc_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // entries read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && wr_i.addr == rd_addr_i) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
      end
      if (wr_i.en && wr_i.addr == ebalu_pkg::ACC_INDEX) begin
        acc_q <= wr_i.data;
      end else begin
        acc_q <= vld_q[ebalu_pkg::ACC_INDEX] ? mem[ebalu_pkg::ACC_INDEX] : '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign acc_o     = acc_q;

endmodule

`default_nettype wire

// ----- sv/ebalu_exec.sv -----
// ----------------------------------------------------------------------------
// ebalu_exec
// Single-pass datapath: computes the new result byte, flags and register
// write for one operation from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module ebalu_exec (
  input  wire  ebalu_pkg::item_t        item_i,
  input  wire  [ebalu_pkg::DATA_W-1:0]  reg_val_i,
  input  wire  [ebalu_pkg::DATA_W-1:0]  acc_i,
  input  wire  ebalu_pkg::flags_t       flags_i,
  input  wire  [ebalu_pkg::DATA_W-1:0]  last_i,
  output ebalu_pkg::flags_t             flags_o,
  output logic [ebalu_pkg::DATA_W-1:0]  last_o,
  output ebalu_pkg::wr_req_t            wr_o
);

  ebalu_pkg::cmd_e              cmd;
  logic [ebalu_pkg::DATA_W-1:0] inc_src;
  logic [ebalu_pkg::DATA_W-1:0] inc_res;
  logic [ebalu_pkg::DATA_W-1:0] dec_res;
  logic [ebalu_pkg::DATA_W-1:0] add_a;
  logic                         cy_in;
  logic [ebalu_pkg::DATA_W:0]   add9;
  logic [4:0]                   addh;
  logic [ebalu_pkg::DATA_W:0]   sub9;
  logic [4:0]                   subh;
  logic [ebalu_pkg::DATA_W-1:0] logic_res;
  logic [ebalu_pkg::DATA_W-1:0] bit_mask;
  logic [ebalu_pkg::DATA_W-1:0] rot_res;
  logic                         rot_c;

  assign cmd = ebalu_pkg::cmd_e'(item_i.cmd);

  always_comb begin
    inc_src = (cmd == ebalu_pkg::CMD_INC_REG || cmd == ebalu_pkg::CMD_DEC_REG)
              ? reg_val_i : item_i.opd;
    inc_res = inc_src + 8'd1;
    dec_res = inc_src - 8'd1;

    add_a = (cmd == ebalu_pkg::CMD_ADD_REG) ? reg_val_i : acc_i;
    cy_in = (cmd == ebalu_pkg::CMD_ADC || cmd == ebalu_pkg::CMD_SBC) ? flags_i.c : 1'b0;
    add9  = {1'b0, add_a} + {1'b0, item_i.opd} + {8'd0, cy_in};
    addh  = {1'b0, add_a[3:0]} + {1'b0, item_i.opd[3:0]} + {4'd0, cy_in};
    // borrow shows up as the extra top bit of the difference
    sub9  = {1'b0, acc_i} - {1'b0, item_i.opd} - {8'd0, cy_in};
    subh  = {1'b0, acc_i[3:0]} - {1'b0, item_i.opd[3:0]} - {4'd0, cy_in};

    unique case (cmd)
      ebalu_pkg::CMD_AND: logic_res = acc_i & item_i.opd;
      ebalu_pkg::CMD_XOR: logic_res = acc_i ^ item_i.opd;
      default:            logic_res = acc_i | item_i.opd;
    endcase

    bit_mask = 8'd1 << item_i.bidx;

    if (cmd == ebalu_pkg::CMD_RL) begin
      rot_res = {reg_val_i[6:0], item_i.circ ? reg_val_i[7] : flags_i.c};
      rot_c   = reg_val_i[7];
    end else begin
      rot_res = {item_i.circ ? reg_val_i[0] : flags_i.c, reg_val_i[7:1]};
      rot_c   = reg_val_i[0];
    end

    flags_o = flags_i;
    last_o  = last_i;
    wr_o    = '{en: 1'b0, addr: item_i.rid, data: reg_val_i};

    unique case (cmd)
      ebalu_pkg::CMD_INC_REG, ebalu_pkg::CMD_INC_VAL: begin
        last_o    = inc_res;
        flags_o.n = 1'b0;
        flags_o.h = (inc_src[3:0] == 4'hF);
        flags_o.z = (inc_res == '0);
        wr_o.en   = (cmd == ebalu_pkg::CMD_INC_REG);
        wr_o.data = inc_res;
      end
      ebalu_pkg::CMD_DEC_REG, ebalu_pkg::CMD_DEC_VAL: begin
        last_o    = dec_res;
        flags_o.n = 1'b1;
        flags_o.h = (inc_src[3:0] == 4'h0);
        flags_o.z = (dec_res == '0);
        wr_o.en   = (cmd == ebalu_pkg::CMD_DEC_REG);
        wr_o.data = dec_res;
      end
      ebalu_pkg::CMD_ADD_REG: begin
        last_o    = add9[7:0];
        flags_o.n = 1'b0;
        flags_o.h = addh[4];
        flags_o.c = add9[8];
        wr_o.en   = 1'b1;
        wr_o.data = add9[7:0];
      end
      ebalu_pkg::CMD_LOAD: begin
        wr_o.en   = 1'b1;
        wr_o.data = item_i.opd;
      end
      ebalu_pkg::CMD_COPY: begin
        // reg_val_i was read from the source register for this command
        wr_o.en   = 1'b1;
      end
      ebalu_pkg::CMD_RL, ebalu_pkg::CMD_RR: begin
        last_o    = rot_res;
        flags_o.c = rot_c;
        flags_o.h = 1'b0;
        flags_o.n = 1'b0;
        wr_o.en   = 1'b1;
        wr_o.data = rot_res;
      end
      ebalu_pkg::CMD_CPL: begin
        last_o    = ~reg_val_i;
        flags_o.h = 1'b1;
        flags_o.n = 1'b1;
        wr_o.en   = 1'b1;
        wr_o.data = ~reg_val_i;
      end
      ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC: begin
        last_o    = add9[7:0];
        flags_o.n = 1'b0;
        flags_o.h = addh[4];
        flags_o.c = add9[8];
        flags_o.z = (add9[7:0] == '0);
        wr_o      = '{en: 1'b1, addr: ebalu_pkg::ACC_INDEX, data: add9[7:0]};
      end
      ebalu_pkg::CMD_SUB, ebalu_pkg::CMD_SBC, ebalu_pkg::CMD_CP: begin
        last_o    = sub9[7:0];
        flags_o.n = 1'b1;
        flags_o.h = subh[4];
        flags_o.c = sub9[8];
        flags_o.z = (sub9[7:0] == '0);
        // compare leaves the accumulator alone
        wr_o      = '{en: (cmd != ebalu_pkg::CMD_CP), addr: ebalu_pkg::ACC_INDEX,
                      data: sub9[7:0]};
      end
      ebalu_pkg::CMD_AND, ebalu_pkg::CMD_XOR, ebalu_pkg::CMD_OR: begin
        last_o    = logic_res;
        flags_o.n = 1'b0;
        flags_o.h = (cmd == ebalu_pkg::CMD_AND);
        flags_o.c = 1'b0;
        flags_o.z = (logic_res == '0);
        wr_o      = '{en: 1'b1, addr: ebalu_pkg::ACC_INDEX, data: logic_res};
      end
      ebalu_pkg::CMD_BIT: begin
        last_o    = {7'd0, item_i.opd[item_i.bidx]};
        flags_o.h = 1'b1;
        flags_o.n = 1'b0;
        flags_o.z = ~item_i.opd[item_i.bidx];
      end
      ebalu_pkg::CMD_RES: last_o = item_i.opd & ~bit_mask;
      ebalu_pkg::CMD_SET: last_o = item_i.opd | bit_mask;
      ebalu_pkg::CMD_SCF: begin
        flags_o.n = 1'b0;
        flags_o.h = 1'b0;
        flags_o.c = 1'b1;
      end
      ebalu_pkg::CMD_CCF: begin
        flags_o.n = 1'b0;
        flags_o.h = 1'b0;
        flags_o.c = ~flags_i.c;
      end
      ebalu_pkg::CMD_CLEAR: last_o = '0;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
